/* rtl/assert_macros.svh */
// Assertion macros shared by the deframer RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lpmd_pkg.sv */
// Package for the length-prefixed message deframer: constants, types and codes.
`default_nettype none

package lpmd_pkg;

   // Stream and header constants
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned ADDR_W = 48;
   localparam logic [BYTE_W-1:0] LONG_LENGTH_MARK = 8'h01;
   localparam logic [LEN_W-1:0] SHORT_HDR_LEN = 16'd1;
   localparam logic [LEN_W-1:0] LONG_HDR_LEN = 16'd3;
   localparam logic [LEN_W-1:0] HI_HDR_COUNT = 16'd2;

   // Configuration registers
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEER_ADDR = 4'd1;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

   // Front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = 2'(QUEUE_DEPTH);

   // Header parser phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LEN_HI = 2'd1,
      PH_LEN_LO = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   // One classified stream byte
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              long_mark;
   } item_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [LEN_W-1:0]  max_len;
      logic [ADDR_W-1:0] peer_addr;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/lpmd_front.sv */
// Front end: accepts stream bytes, tags the long-length marker, queues them.
`default_nettype none

`include "assert_macros.svh"

module lpmd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [lpmd_pkg::BYTE_W-1:0] req_data_byte,
   output logic                            req_stall,
   output logic                            q_valid,
   output lpmd_pkg::item_type              q_item,
   input  wire logic                       q_pop
);

   lpmd_pkg::item_type                      mem_ff [lpmd_pkg::QUEUE_DEPTH];
   logic [lpmd_pkg::QUEUE_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lpmd_pkg::QUEUE_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lpmd_pkg::QUEUE_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                    push;
   lpmd_pkg::item_type                      new_item;

   // Classify the incoming byte
   always_comb begin
      new_item.data      = req_data_byte;
      new_item.long_mark = (req_data_byte == lpmd_pkg::LONG_LENGTH_MARK);
   end

   assign req_stall = (cnt_ff == lpmd_pkg::QUEUE_FULL);
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   `ASSERT_NOW(a_pop_nonempty, q_pop, cnt_ff != '0, "pop from empty queue")
   `ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= lpmd_pkg::QUEUE_FULL, "queue count overflow")

endmodule

`default_nettype wire

/* rtl/lpmd_back.sv */
// Back end: header parser, byte counter and registered result stage.
`default_nettype none

`include "assert_macros.svh"

module lpmd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire lpmd_pkg::item_type          q_item,
   output logic                             q_pop,
   input  wire lpmd_pkg::cfg_type           cfg,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lpmd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_first_of_message,
   output logic                             rsp_last_of_message,
   output logic                             rsp_framing_error,
   output logic [lpmd_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic [lpmd_pkg::ADDR_W-1:0]      rsp_message_address
);

   lpmd_pkg::phase_type               phase_ff, phase_in;
   logic [lpmd_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [lpmd_pkg::LEN_W-1:0]        count_ff, count_in;
   logic [lpmd_pkg::LEN_W-1:0]        count_inc;
   logic [lpmd_pkg::LEN_W-1:0]        hdr_len, cand_len, mlen;
   logic                              check, first, last, err;
   logic                              advance;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lpmd_pkg::BYTE_W-1:0]       byte_ff;
   logic                              first_ff, last_ff, err_ff;
   logic [lpmd_pkg::LEN_W-1:0]        mlen_ff;
   logic [lpmd_pkg::ADDR_W-1:0]       addr_ff;

   // Take the next item when the result register is free or being drained
   assign advance      = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign q_pop        = advance;
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign count_inc    = count_ff + 16'd1;

   // Header parse and body count
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      first    = 1'b0;
      last     = 1'b0;
      err      = 1'b0;
      mlen     = '0;
      check    = 1'b0;
      hdr_len  = '0;
      cand_len = '0;
      unique case (phase_ff)
         lpmd_pkg::PH_IDLE: begin
            first = 1'b1;
            if (q_item.long_mark) begin
               phase_in = lpmd_pkg::PH_LEN_HI;
               len_in   = '0;
               count_in = lpmd_pkg::SHORT_HDR_LEN;
            end else begin
               check    = 1'b1;
               hdr_len  = lpmd_pkg::SHORT_HDR_LEN;
               cand_len = {8'h00, q_item.data};
            end
         end
         lpmd_pkg::PH_LEN_HI: begin
            len_in   = {q_item.data, 8'h00};
            count_in = lpmd_pkg::HI_HDR_COUNT;
            phase_in = lpmd_pkg::PH_LEN_LO;
         end
         lpmd_pkg::PH_LEN_LO: begin
            check    = 1'b1;
            hdr_len  = lpmd_pkg::LONG_HDR_LEN;
            cand_len = {len_ff[15:8], q_item.data};
         end
         lpmd_pkg::PH_BODY: begin
            mlen     = len_ff;
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               last     = 1'b1;
               phase_in = lpmd_pkg::PH_IDLE;
               len_in   = '0;
               count_in = '0;
            end
         end
         default: begin
            phase_in = lpmd_pkg::PH_IDLE;
         end
      endcase

      // Length field complete: validate against header size and maximum
      if (check) begin
         mlen = cand_len;
         if ((cand_len < hdr_len) || (cand_len > cfg.max_len)) begin
            err      = 1'b1;
            phase_in = lpmd_pkg::PH_IDLE;
            len_in   = '0;
            count_in = '0;
         end else if (cand_len == hdr_len) begin
            last     = 1'b1;
            phase_in = lpmd_pkg::PH_IDLE;
            len_in   = '0;
            count_in = '0;
         end else begin
            phase_in = lpmd_pkg::PH_BODY;
            len_in   = cand_len;
            count_in = hdr_len;
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpmd_pkg::PH_IDLE;
         len_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            count_ff <= count_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff  <= q_item.data;
         first_ff <= first;
         last_ff  <= last;
         err_ff   <= err;
         mlen_ff  <= mlen;
         addr_ff  <= cfg.peer_addr;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_first_of_message = first_ff;
   assign rsp_last_of_message  = last_ff;
   assign rsp_framing_error    = err_ff;
   assign rsp_frame_length     = mlen_ff;
   assign rsp_message_address  = addr_ff;

   `ASSERT_NOW(a_last_err_excl, rsp_valid_ff, !(last_ff && err_ff), "last and error together")
   `ASSERT_NEXT(a_end_to_idle, advance && (last || err), phase_ff == lpmd_pkg::PH_IDLE, "not idle after message end")
   `ASSERT_NEXT(a_hold_stalled, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(byte_ff), "stalled result changed")

endmodule

`default_nettype wire

/* rtl/length_prefixed_message_deframer_core.sv */
// Top level of the length-prefixed message deframer: config registers and the two ends.
// Splits a connection byte stream into length-prefixed messages: a first byte of 0x01
// means two big-endian length bytes follow, otherwise that byte is the total length.
// Each accepted byte yields exactly one result carrying the byte, first/last marks, a
// framing error flag, the decoded length and the configured peer address. Sustained
// rate is one byte per clock while rsp_stall is low; an accepted byte is first written
// into the two-entry input queue and is then parsed into the result register by the
// back end. The result side may stall freely; up to two further bytes are buffered
// before req_stall rises.
// Configuration writes are always accepted (csr_ready is high); index 0 is the
// maximum message length (reset 1024), index 1 the peer address, other indexes are
// ignored. Write configuration only while no byte is in flight.
`default_nettype none

module length_prefixed_message_deframer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // stream input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lpmd_pkg::BYTE_W-1:0]      req_data_byte,
   // results
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lpmd_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                  rsp_first_of_message,
   output logic                                  rsp_last_of_message,
   output logic                                  rsp_framing_error,
   output logic [lpmd_pkg::LEN_W-1:0]            rsp_frame_length,
   output logic [lpmd_pkg::ADDR_W-1:0]           rsp_message_address,
   // configuration writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lpmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lpmd_pkg::ADDR_W-1:0]      csr_wdata
);

   logic [lpmd_pkg::LEN_W-1:0]  max_len_ff;
   logic [lpmd_pkg::ADDR_W-1:0] peer_addr_ff;
   lpmd_pkg::cfg_type           cfg;
   logic                        q_valid;
   logic                        q_pop;
   lpmd_pkg::item_type          q_item;
   logic                        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= lpmd_pkg::MAX_LEN_RESET;
         peer_addr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            lpmd_pkg::CSR_MAX_LEN:   max_len_ff   <= csr_wdata[lpmd_pkg::LEN_W-1:0];
            lpmd_pkg::CSR_PEER_ADDR: peer_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.max_len   = max_len_ff;
      cfg.peer_addr = peer_addr_ff;
   end

   lpmd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   lpmd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .cfg                  (cfg),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_first_of_message (rsp_first_of_message),
      .rsp_last_of_message  (rsp_last_of_message),
      .rsp_framing_error    (rsp_framing_error),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_message_address  (rsp_message_address)
   );

endmodule

`default_nettype wire
